### sv/integer_to_ascii_formatter_assert.svh
// Assertion macros used by the top level of the integer to ASCII formatter RTL.
`ifndef INTEGER_TO_ASCII_FORMATTER_ASSERT_SVH
`define INTEGER_TO_ASCII_FORMATTER_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define I2A_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that cons holds in the cycle after ante.
`define I2A_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### sv/i2a_pkg.sv
// Package with codes, command and status types and the digit encoder of the formatter.
`timescale 1ns / 1ps
package i2a_pkg;

	localparam int KIND_W  = 3;
	localparam int VALUE_W = 64;
	localparam int CHAR_W  = 8;

	localparam logic [KIND_W-1:0] KIND_SDEC = 3'd0;
	localparam logic [KIND_W-1:0] KIND_UDEC = 3'd1;
	localparam logic [KIND_W-1:0] KIND_OCT  = 3'd2;
	localparam logic [KIND_W-1:0] KIND_HEXL = 3'd3;
	localparam logic [KIND_W-1:0] KIND_HEXU = 3'd4;
	localparam logic [KIND_W-1:0] KIND_PTR  = 3'd5;
	localparam logic [KIND_W-1:0] KIND_CHAR = 3'd6;

	localparam int NUM_NIBBLES   = 16;
	localparam int NIB_IDX_W     = $clog2(NUM_NIBBLES);
	localparam int DEC_DIGITS    = 10;
	localparam int OCT_DIGITS    = 11;
	localparam int BIN_W         = 32;
	localparam int BITS_PER_STEP = 4;
	localparam int DABBLE_STEPS  = BIN_W / BITS_PER_STEP;
	localparam int STEP_CNT_W    = $clog2(DABBLE_STEPS);

	localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'h2d;
	localparam logic [CHAR_W-1:0] ASCII_X     = 8'h78;
	localparam logic [CHAR_W-1:0] ASCII_LA    = 8'h61;
	localparam logic [CHAR_W-1:0] ASCII_UA    = 8'h41;

	typedef enum logic [2:0] {
		SEL_MINUS,
		SEL_ZERO,
		SEL_X,
		SEL_DIGIT,
		SEL_BYTE
	} sel_t;

	typedef struct packed {
		logic load;
		logic dabble;
		logic count;
		logic emit;
		logic dec_idx;
		sel_t sel;
		logic last;
		logic upper;
	} cmd_t;

	typedef struct packed {
		logic neg_in;
		logic idx_zero;
		logic out_free;
	} status_t;

	function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] nib, input logic upper);
		logic [CHAR_W-1:0] base;
		base = upper ? ASCII_UA : ASCII_LA;
		if (nib < 4'd10) begin
			return ASCII_ZERO + {4'b0, nib};
		end else begin
			return base + {4'b0, nib} - 8'd10;
		end
	endfunction

endpackage

### sv/integer_to_ascii_formatter.sv
// Top level of the integer to ASCII formatter: controller, datapath and checks.
//
// Usage: present a request beat (kind, value) on in_valid/in_ready. The block
// answers with a stream of character beats on out_valid/out_ready, most
// significant character first, with last set on the final one. Kinds: signed
// decimal, unsigned decimal, octal, lower and upper hex on the low 32 bits,
// pointer ("0x" plus hex of all 64 bits) and a raw character. Kind 7 is
// accepted and dropped without any output beat.
// Timing: after the request beat, decimal kinds pass through the binary to BCD
// unit (four bits a cycle), every numeric kind then locates its leading digit,
// and each character then passes through the output register; at most 18
// characters are emitted per request.
// One request is in work at a time; in_ready rises as soon as the last
// character sits in the output register, so the next request is taken while
// that beat still waits.
// Reset clears the controller and the output valid flag; a stalled receiver
// simply holds the current character beat and pauses the character loop.
`timescale 1ns / 1ps
module integer_to_ascii_formatter (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [i2a_pkg::KIND_W-1:0]  kind,
	input  logic [i2a_pkg::VALUE_W-1:0] value,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [i2a_pkg::CHAR_W-1:0]  out_char,
	output logic                        last
);
	import i2a_pkg::*;

	`include "integer_to_ascii_formatter_assert.svh"

	cmd_t    cmd;
	status_t st;

	// Sequence the request: load, convert decimal values, count, then emit beat by beat.
	i2a_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.kind     (kind),
		.st       (st),
		.cmd      (cmd)
	);

	// Hold the digits and drive the output register.
	i2a_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.kind      (kind),
		.value     (value),
		.cmd       (cmd),
		.st        (st),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_char  (out_char),
		.last      (last)
	);

	// A character may only enter an output register that is free.
	`I2A_ASSERT_IMP(a_emit_free, cmd.emit, st.out_free, "character loaded over a held beat")
	// While waiting for a request, no character is produced.
	`I2A_ASSERT_IMP(a_idle_quiet, in_ready, !cmd.emit && !cmd.dabble, "work while idle")
	// After the final character, take the next request at once.
	`I2A_ASSERT_NEXT(a_last_idle, cmd.emit && cmd.last, in_ready, "no return to idle after last")

endmodule

### sv/i2a_datapath.sv
// Datapath of the formatter: digit buffer, binary to BCD unit and output register.
`timescale 1ns / 1ps
module i2a_datapath (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [i2a_pkg::KIND_W-1:0]  kind,
	input  logic [i2a_pkg::VALUE_W-1:0] value,
	input  i2a_pkg::cmd_t               cmd,
	output i2a_pkg::status_t            st,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [i2a_pkg::CHAR_W-1:0]  out_char,
	output logic                        last
);
	import i2a_pkg::*;

	logic [NUM_NIBBLES-1:0][3:0] dig_q;
	logic [BIN_W-1:0]            bin_q;
	logic [NIB_IDX_W-1:0]        idx_q;
	logic                        out_valid_q;
	logic [CHAR_W-1:0]           out_char_q;
	logic                        last_q;

	logic [BIN_W-1:0]            lo;
	logic [NUM_NIBBLES-1:0][3:0] oct_nib;
	logic [DEC_DIGITS-1:0][3:0]  bcd_nxt;
	logic [BIN_W-1:0]            bin_nxt;
	logic [NIB_IDX_W-1:0]        top_nib;
	logic [CHAR_W-1:0]           char_nxt;

	assign lo = value[BIN_W-1:0];

	// Spread the octal digits of the low word over nibbles.
	always_comb begin
		logic [3*OCT_DIGITS-1:0] lo_ext;
		lo_ext  = {{(3*OCT_DIGITS-BIN_W){1'b0}}, lo};
		oct_nib = '0;
		for (int i = 0; i < OCT_DIGITS; i++) begin
			oct_nib[i] = {1'b0, lo_ext[3*i +: 3]};
		end
	end

	// Shift-add-3 over several bits per cycle.
	always_comb begin
		logic [DEC_DIGITS*4+BIN_W-1:0] sh;
		logic [DEC_DIGITS-1:0][3:0]    d;
		logic [BIN_W-1:0]              b;
		d = dig_q[DEC_DIGITS-1:0];
		b = bin_q;
		for (int s = 0; s < BITS_PER_STEP; s++) begin
			for (int i = 0; i < DEC_DIGITS; i++) begin
				if (d[i] >= 4'd5) begin
					d[i] = d[i] + 4'd3;
				end
			end
			sh = {d, b} << 1;
			d  = sh[DEC_DIGITS*4+BIN_W-1:BIN_W];
			b  = sh[BIN_W-1:0];
		end
		bcd_nxt = d;
		bin_nxt = b;
	end

	// Locate the most significant non-zero digit; zero keeps one digit.
	always_comb begin
		top_nib = '0;
		for (int i = 0; i < NUM_NIBBLES; i++) begin
			if (dig_q[i] != 4'd0) begin
				top_nib = NIB_IDX_W'(i);
			end
		end
	end

	always_comb begin
		unique case (cmd.sel)
			SEL_MINUS: char_nxt = ASCII_MINUS;
			SEL_ZERO:  char_nxt = ASCII_ZERO;
			SEL_X:     char_nxt = ASCII_X;
			SEL_DIGIT: char_nxt = digit_char(dig_q[idx_q], cmd.upper);
			SEL_BYTE:  char_nxt = {dig_q[1], dig_q[0]};
			default:   char_nxt = ASCII_ZERO;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			unique case (kind)
				KIND_SDEC: begin
					bin_q <= lo[BIN_W-1] ? (~lo + 1'b1) : lo;
					dig_q <= '0;
				end
				KIND_UDEC: begin
					bin_q <= lo;
					dig_q <= '0;
				end
				KIND_OCT:             dig_q <= oct_nib;
				KIND_HEXL, KIND_HEXU: dig_q <= {{(VALUE_W-BIN_W){1'b0}}, lo};
				default:              dig_q <= value;
			endcase
		end else if (cmd.dabble) begin
			dig_q[DEC_DIGITS-1:0] <= bcd_nxt;
			bin_q                 <= bin_nxt;
		end
		if (cmd.count) begin
			idx_q <= top_nib;
		end else if (cmd.dec_idx) begin
			idx_q <= idx_q - 1'b1;
		end
		if (cmd.emit) begin
			out_char_q <= char_nxt;
			last_q     <= cmd.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign st.neg_in   = lo[BIN_W-1];
	assign st.idx_zero = (idx_q == '0);
	assign st.out_free = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign out_char  = out_char_q;
	assign last      = last_q;

endmodule

### sv/i2a_ctrl.sv
// Controller state machine of the formatter.
`timescale 1ns / 1ps
module i2a_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [i2a_pkg::KIND_W-1:0] kind,
	input  i2a_pkg::status_t           st,
	output i2a_pkg::cmd_t              cmd
);
	import i2a_pkg::*;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_CONV  = 3'd1;
	localparam logic [2:0] S_COUNT = 3'd2;
	localparam logic [2:0] S_PRE   = 3'd3;
	localparam logic [2:0] S_EMIT  = 3'd4;
	localparam logic [2:0] S_BYTE  = 3'd5;

	logic [2:0]            state_q, state_d;
	logic [KIND_W-1:0]     kind_q;
	logic                  neg_q;
	logic                  pre_q;
	logic [STEP_CNT_W-1:0] cnt_q;
	logic                  accept;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;

	always_comb begin
		state_d     = state_q;
		cmd         = '0;
		cmd.sel     = SEL_DIGIT;
		cmd.upper   = (kind_q == KIND_HEXU);
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					cmd.load = 1'b1;
					if (kind == KIND_SDEC || kind == KIND_UDEC) begin
						state_d = S_CONV;
					end else if (kind == KIND_CHAR) begin
						state_d = S_BYTE;
					end else if (kind == KIND_OCT || kind == KIND_HEXL ||
						kind == KIND_HEXU || kind == KIND_PTR) begin
						state_d = S_COUNT;
					end
				end
			end
			S_CONV: begin
				cmd.dabble = 1'b1;
				if (cnt_q == STEP_CNT_W'(DABBLE_STEPS - 1)) begin
					state_d = S_COUNT;
				end
			end
			S_COUNT: begin
				cmd.count = 1'b1;
				state_d   = (neg_q || kind_q == KIND_PTR) ? S_PRE : S_EMIT;
			end
			S_PRE: begin
				if (st.out_free) begin
					cmd.emit = 1'b1;
					if (neg_q) begin
						cmd.sel = SEL_MINUS;
						state_d = S_EMIT;
					end else if (!pre_q) begin
						cmd.sel = SEL_ZERO;
					end else begin
						cmd.sel = SEL_X;
						state_d = S_EMIT;
					end
				end
			end
			S_EMIT: begin
				if (st.out_free) begin
					cmd.emit    = 1'b1;
					cmd.dec_idx = 1'b1;
					cmd.last    = st.idx_zero;
					if (st.idx_zero) begin
						state_d = S_IDLE;
					end
				end
			end
			S_BYTE: begin
				if (st.out_free) begin
					cmd.emit = 1'b1;
					cmd.sel  = SEL_BYTE;
					cmd.last = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			kind_q  <= KIND_SDEC;
			neg_q   <= 1'b0;
			pre_q   <= 1'b0;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				kind_q <= kind;
				neg_q  <= (kind == KIND_SDEC) && st.neg_in;
				pre_q  <= 1'b0;
				cnt_q  <= '0;
			end else begin
				if (cmd.dabble) begin
					cnt_q <= cnt_q + 1'b1;
				end
				if (state_q == S_PRE && cmd.emit) begin
					pre_q <= 1'b1;
				end
			end
		end
	end

endmodule

### tb/sv/integer_to_ascii_formatter_tb.sv
// Testbench for the integer to ASCII formatter: queued request driver, character monitor, checks.
`timescale 1ns / 1ps
module integer_to_ascii_formatter_tb;
	import i2a_pkg::*;

	// Kind 7 has no meaning; the block takes the beat and emits nothing.
	localparam logic [KIND_W-1:0] KIND_UNUSED = 3'd7;

	localparam logic [CHAR_W-1:0] CH_ZERO  = "0";
	localparam logic [CHAR_W-1:0] CH_MINUS = "-";
	localparam logic [CHAR_W-1:0] CH_X     = "x";
	localparam logic [CHAR_W-1:0] CH_LA    = "a";
	localparam logic [CHAR_W-1:0] CH_UA    = "A";

	localparam int RANDOM_REQS = 400;

	// One pending request; drain_first holds it back until every character
	// already predicted has come out.
	typedef struct packed {
		logic [KIND_W-1:0]  kind;
		logic [VALUE_W-1:0] value;
		logic               drain_first;
	} fmt_req_t;

	typedef struct packed {
		logic [CHAR_W-1:0] ch;
		logic              last;
	} char_beat_t;

	// Receiver stall patterns.
	typedef enum logic [1:0] {
		RX_OPEN,
		RX_COIN,
		RX_COMB,
		RX_CHOKE
	} rx_mode_t;

	logic                clk       = 1'b0;
	logic                arst_n    = 1'b0;
	logic                in_valid  = 1'b0;
	logic                in_ready;
	logic [KIND_W-1:0]   kind      = '0;
	logic [VALUE_W-1:0]  value     = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic [CHAR_W-1:0]   out_char;
	logic                last;

	fmt_req_t   pending_reqs[$];
	char_beat_t expected_chars[$];

	// Request beats presented by the driver and taken by the block.
	int       reqs_sent = 0;
	int       reqs_taken = 0;
	int       burst_left = 0;
	int       gap_left = 0;
	rx_mode_t rx_mode = RX_OPEN;
	int       rx_mode_left = 0;
	int       rx_choke_left = 0;
	int       rx_tick = 0;

	int errors = 0;
	int chars_checked = 0;
	int lines_done = 0;
	int reqs_per_kind[8];

	integer_to_ascii_formatter dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.kind      (kind),
		.value     (value),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_char  (out_char),
		.last      (last)
	);

	always #5 clk = ~clk;

	// Work out the characters one request must produce and append them to the
	// store of expected beats, last flag on the final one.
	task automatic predict_chars(input logic [KIND_W-1:0] k, input logic [VALUE_W-1:0] v);
		logic [CHAR_W-1:0] text[$];
		logic [CHAR_W-1:0] digs[$];
		logic [31:0]       lo;
		logic [63:0]       mag;
		logic [63:0]       radix;
		logic [63:0]       d;
		logic              upper;
		bit                numeric;
		char_beat_t        beat;
		lo      = v[31:0];
		mag     = {32'd0, lo};
		radix   = 64'd10;
		upper   = 1'b0;
		numeric = 1'b1;
		case (k)
			KIND_SDEC: begin
				// Negate in 32 bits; the most negative int keeps its full magnitude.
				if (lo[31]) begin
					text.push_back(CH_MINUS);
					mag = {32'd0, ~lo + 32'd1};
				end
			end
			KIND_UDEC: ;
			KIND_OCT:  radix = 64'd8;
			KIND_HEXL: radix = 64'd16;
			KIND_HEXU: begin
				radix = 64'd16;
				upper = 1'b1;
			end
			KIND_PTR: begin
				text.push_back(CH_ZERO);
				text.push_back(CH_X);
				mag   = v;
				radix = 64'd16;
			end
			KIND_CHAR: begin
				text.push_back(v[7:0]);
				numeric = 1'b0;
			end
			default: numeric = 1'b0;
		endcase
		if (numeric) begin
			do begin
				d = mag % radix;
				digs.push_front(d < 64'd10 ? CH_ZERO + d[7:0]
					: (upper ? CH_UA : CH_LA) + d[7:0] - 8'd10);
				mag = mag / radix;
			end while (mag != 64'd0);
			foreach (digs[i])
				text.push_back(digs[i]);
		end
		foreach (text[i]) begin
			beat.ch   = text[i];
			beat.last = (i == text.size() - 1);
			expected_chars.push_back(beat);
		end
	endtask

	task automatic add_req(input logic [KIND_W-1:0] k, input logic [VALUE_W-1:0] v,
			input bit drain);
		fmt_req_t r;
		r.kind        = k;
		r.value       = v;
		r.drain_first = drain;
		pending_reqs.push_back(r);
	endtask

	function automatic logic [VALUE_W-1:0] rand_value();
		logic [VALUE_W-1:0] v;
		v = {$urandom, $urandom};
		case ($urandom_range(0, 4))
			0: ;                                    // full random
			1: v = VALUE_W'($urandom_range(0, 20)); // few digits
			2: v = v >> $urandom_range(0, 63);      // any length
			3: begin
				// boundaries of the low word, random upper word
				case ($urandom_range(0, 3))
					0: v[31:0] = 32'h8000_0000;
					1: v[31:0] = 32'h7fff_ffff;
					2: v[31:0] = 32'hffff_ffff;
					default: v[31:0] = 32'h0000_0000;
				endcase
			end
			default: v = v & ((64'd1 << $urandom_range(1, 40)) - 64'd1);
		endcase
		return v;
	endfunction

	// Driver: present request beats at the falling edge, in bursts with gaps.
	always @(negedge clk) begin
		if (arst_n) begin
			if (in_valid && reqs_taken != reqs_sent) begin
				// hold: beat still waiting for in_ready
			end else begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (pending_reqs.size() == 0) begin
					in_valid <= 1'b0;
				end else if (pending_reqs[0].drain_first && expected_chars.size() != 0) begin
					// hold off until the receiver has seen everything predicted
					in_valid <= 1'b0;
				end else begin
					in_valid <= 1'b1;
					kind     <= pending_reqs[0].kind;
					value    <= pending_reqs[0].value;
					void'(pending_reqs.pop_front());
					reqs_sent++;
					if (burst_left > 0)
						burst_left--;
					if (burst_left == 0) begin
						burst_left = $urandom_range(1, 16);
						gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
					end
				end
			end
		end
	end

	// Receiver: out_ready follows a stall pattern that changes now and then.
	always @(negedge clk) begin
		if (arst_n) begin
			if (rx_mode_left == 0) begin
				rx_mode      = rx_mode_t'($urandom_range(0, 3));
				rx_mode_left = $urandom_range(20, 200);
			end
			rx_mode_left--;
			rx_tick++;
			case (rx_mode)
				RX_OPEN: out_ready <= 1'b1;
				RX_COIN: out_ready <= 1'($urandom_range(0, 1));
				RX_COMB: out_ready <= (rx_tick % 3) != 0;
				default: begin
					if (rx_choke_left > 0) begin
						rx_choke_left--;
						out_ready <= 1'b0;
					end else if ($urandom_range(0, 7) == 0) begin
						rx_choke_left = $urandom_range(1, 20);
						out_ready <= 1'b0;
					end else begin
						out_ready <= 1'b1;
					end
				end
			endcase
		end
	end

	// Monitor: predict on each accepted request beat, check each character beat.
	always @(posedge clk) begin
		char_beat_t exp_beat;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				predict_chars(kind, value);
				reqs_per_kind[kind]++;
				reqs_taken++;
			end
			if (out_valid && out_ready) begin
				if (expected_chars.size() == 0) begin
					$display("%0t: unexpected character beat, got char %h last %b",
						$time, out_char, last);
					errors++;
				end else begin
					exp_beat = expected_chars.pop_front();
					chars_checked++;
					if (out_char !== exp_beat.ch) begin
						$display("%0t: out_char mismatch, expected %h, actual %h",
							$time, exp_beat.ch, out_char);
						errors++;
					end
					if (last !== exp_beat.last) begin
						$display("%0t: last mismatch, expected %b, actual %b",
							$time, exp_beat.last, last);
						errors++;
					end
					if (exp_beat.last)
						lines_done++;
				end
			end
		end
	end

	// Stimulus and end of run.
	initial begin
		int useful;
		logic [KIND_W-1:0] k;
		foreach (reqs_per_kind[i])
			reqs_per_kind[i] = 0;

		// Directed: extremes of every kind, most negative int, unused kind,
		// high word ignored, longest pointer.
		add_req(KIND_SDEC, 64'h0, 1'b0);
		add_req(KIND_SDEC, 64'hffff_ffff, 1'b0);
		add_req(KIND_SDEC, 64'h0000_0000_8000_0000, 1'b0);
		add_req(KIND_SDEC, 64'hffff_ffff_7fff_ffff, 1'b0);
		add_req(KIND_SDEC, 64'hdead_beef_0000_0005, 1'b0);
		add_req(KIND_UDEC, 64'h0, 1'b0);
		add_req(KIND_UDEC, 64'hffff_ffff_ffff_ffff, 1'b0);
		add_req(KIND_UDEC, 64'd10, 1'b0);
		add_req(KIND_OCT, 64'h0, 1'b0);
		add_req(KIND_OCT, 64'hffff_ffff, 1'b0);
		add_req(KIND_OCT, 64'd8, 1'b0);
		add_req(KIND_HEXL, 64'h0, 1'b0);
		add_req(KIND_HEXL, 64'h1234_5678_abcd_ef09, 1'b0);
		add_req(KIND_HEXU, 64'hffff_ffff, 1'b0);
		add_req(KIND_HEXU, 64'h0000_0000_abcd_ef01, 1'b0);
		add_req(KIND_PTR, 64'h0, 1'b0);
		add_req(KIND_PTR, 64'hffff_ffff_ffff_ffff, 1'b0);
		add_req(KIND_PTR, 64'h8000_0000_0000_0000, 1'b0);
		add_req(KIND_CHAR, 64'h0, 1'b0);
		add_req(KIND_CHAR, 64'hffff_ffff_ffff_ffff, 1'b0);
		add_req(KIND_UNUSED, 64'hffff_ffff_ffff_ffff, 1'b0);
		add_req(KIND_UNUSED, 64'h0, 1'b0);

		// Random: the first one waits for the directed part to drain.
		useful = 0;
		while (useful < RANDOM_REQS) begin
			k = ($urandom_range(0, 19) == 0) ? KIND_UNUSED : KIND_W'($urandom_range(0, 6));
			add_req(k, rand_value(), (useful == 0) || ($urandom_range(0, 49) == 0));
			if (k != KIND_UNUSED)
				useful++;
		end

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_reqs.size() != 0 || in_valid)
			@(posedge clk);
		while (expected_chars.size() != 0)
			@(posedge clk);
		// let any stray beat surface
		repeat (40) @(posedge clk);

		$display("Run covered %0d conversion requests (%0d of the unused kind), %0d lines",
			reqs_per_kind.sum() , reqs_per_kind[KIND_UNUSED], lines_done);
		$display("and %0d character beats checked under varied sender and receiver stalls",
			chars_checked);
		if (errors == 0) begin
			$display("integer_to_ascii_formatter verification clean");
		end else begin
			$display("integer_to_ascii_formatter verification failed");
		end
		$finish;
	end

	// Watchdog: several times the slowest legal run.
	initial begin
		#5_000_000;
		$display("integer_to_ascii_formatter verification failed");
		$finish;
	end

endmodule

### files.f
+incdir+sv
sv/i2a_pkg.sv
sv/i2a_datapath.sv
sv/i2a_ctrl.sv
sv/integer_to_ascii_formatter.sv
tb/sv/integer_to_ascii_formatter_tb.sv
